// ===== hw/rtl/kbw_pkg.sv =====
`timescale 1ns / 1ps
package kbw_pkg;

  localparam int FRAC = 60;
  localparam int NCOEF = 12;
  localparam int DIV_STEPS = FRAC;
  localparam int MAC_LAT = 3;

  typedef struct packed {
    logic valid;
    logic inw;
  } kbw_ctl_t;

  // floor(mant * 2^60 / den) by restoring long division, elaboration only
  function automatic logic [63:0] coef_q60(input logic [63:0] mant, input logic [127:0] den);
    logic [127:0] n;
    logic [127:0] rem;
    logic [63:0] q;
    n = {64'd0, mant} << FRAC;
    rem = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], n[i]};
      q = {q[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // index 0 is the lowest-order term
  localparam logic [63:0] COEF [NCOEF] = '{
    coef_q60(64'd114618222126928749, 128'd1000000000000000000),
    coef_q60(64'd282809127387243423, 128'd1000000000000000000),
    coef_q60(64'd310134912036597639, 128'd1000000000000000000),
    coef_q60(64'd191306805797991572, 128'd1000000000000000000),
    coef_q60(64'd755248996984881942, 128'd10000000000000000000),
    coef_q60(64'd207055800682230959, 128'd10000000000000000000),
    coef_q60(64'd417052824833556674, 128'd100000000000000000000),
    coef_q60(64'd643147874291253173, 128'd1000000000000000000000),
    coef_q60(64'd783656184031631837, 128'd10000000000000000000000),
    coef_q60(64'd773437652285948594, 128'd100000000000000000000000),
    coef_q60(64'd630869723716497460, 128'd1000000000000000000000000),
    coef_q60(64'd432391291785164657, 128'd10000000000000000000000000)
  };

endpackage

// ===== hw/rtl/kaiser_bessel_window_eval.sv =====
`timescale 1ns / 1ps
// Modified Kaiser-Bessel window (alpha 2 pi) evaluator.
// Input: pulse start with position (signed Q16.16); a word is taken at any
// clock edge with start high and busy low. busy is always low: one position
// per clock, back to back, sustained.
// Output: done strobes for one cycle with window_value (unsigned
// Q1.OUT_FRAC_BITS, rounded half up, saturated at 1.0) and in_window.
// Positions with 2|x| >= W give zero and in_window low.
// Config: cfg_wr_en/cfg_wr_data write the window width W (unsigned Q16.16);
// write only while no word is in flight. W resets to 1.0.
// The pipeline holds one input stage, 60 stages of the
// bit-per-stage divider for r = 2|x|/W, a 3-stage multiplier for r*r, one
// stage for 1 - r*r, twelve 3-stage multiply-add units for the Horner chain
// and one rounding stage.
// The receiver cannot stall; done is never held off. Synchronous reset
// flushes all words in flight and restores W.
module kaiser_bessel_window_eval
  import kbw_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       position,
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data,
  output logic                     done,
  output logic [OUT_FRAC_BITS:0]   window_value,
  output logic                     in_window
);

  localparam int SHIFT = FRAC - OUT_FRAC_BITS;
  localparam logic [63:0] ONE = 64'd1 << OUT_FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (SHIFT - 1);
  localparam int LATENCY = 1 + DIV_STEPS + MAC_LAT + 1 + NCOEF * MAC_LAT + 1;

  logic [31:0] width;

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= 32'd65536;
    end else if (cfg_wr_en) begin
      width <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // input stage: |x|, 2|x| and the window test
  logic [32:0] mag;
  logic [33:0] num;
  kbw_ctl_t    ctl_in;
  logic [31:0] num_in;

  assign mag = position[31] ? (33'h1_0000_0000 - {1'b0, position}) : {1'b0, position};
  assign num = {mag, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_in.valid <= 1'b0;
    end else begin
      ctl_in.valid <= start && !busy;
    end
    ctl_in.inw <= num < {2'b00, width};
    num_in     <= num[31:0];
  end

  kbw_ctl_t        ctl_div;
  logic [FRAC-1:0] r;

  kbw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .width   (width),
    .ctl_in  (ctl_in),
    .num_in  (num_in),
    .ctl_out (ctl_div),
    .quo_out (r)
  );

  kbw_ctl_t    ctl_sq;
  logic [63:0] sq;

  kbw_mac u_sq (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_div),
    .a       ({{(64-FRAC){1'b0}}, r}),
    .b       ({{(64-FRAC){1'b0}}, r}),
    .c       (64'd0),
    .aux_in  (64'd0),
    .ctl_out (ctl_sq),
    .result  (sq),
    .aux_out ()
  );

  kbw_ctl_t    ctl_arg;
  logic [63:0] arg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_arg.valid <= 1'b0;
    end else begin
      ctl_arg.valid <= ctl_sq.valid;
    end
    ctl_arg.inw <= ctl_sq.inw;
    arg <= (64'd1 << FRAC) - sq;
  end

  // Horner chain: p = c12, then p = arg*p + ci, last stage w = arg*p
  kbw_ctl_t    ctl_h [NCOEF];
  logic [63:0] p_h   [NCOEF];
  logic [63:0] arg_h [NCOEF];

  for (genvar k = 0; k < NCOEF; k++) begin : g_horner
    kbw_ctl_t    c_ctl;
    logic [63:0] c_arg;
    logic [63:0] c_p;
    logic [63:0] c_add;

    if (k == 0) begin : g_first
      assign c_ctl = ctl_arg;
      assign c_arg = arg;
      assign c_p   = COEF[NCOEF-1];
    end else begin : g_next
      assign c_ctl = ctl_h[k-1];
      assign c_arg = arg_h[k-1];
      assign c_p   = p_h[k-1];
    end

    if (k < NCOEF - 1) begin : g_coef
      assign c_add = COEF[NCOEF-2-k];
    end else begin : g_last
      assign c_add = 64'd0;
    end

    kbw_mac u_mac (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (c_ctl),
      .a       (c_arg),
      .b       (c_p),
      .c       (c_add),
      .aux_in  (c_arg),
      .ctl_out (ctl_h[k]),
      .result  (p_h[k]),
      .aux_out (arg_h[k])
    );
  end

  // round half up, saturate at 1.0
  logic [63:0] w_round;
  logic [63:0] w_val;

  assign w_round = (p_h[NCOEF-1] + HALF) >> SHIFT;
  assign w_val   = (w_round > ONE) ? ONE : w_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_h[NCOEF-1].valid;
    end
    in_window    <= ctl_h[NCOEF-1].inw;
    window_value <= ctl_h[NCOEF-1].inw ? w_val[OUT_FRAC_BITS:0] : '0;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("word accepted but no result after fixed latency");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> window_value <= ONE[OUT_FRAC_BITS:0])
    else $error("window value above 1.0");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && !in_window |-> window_value == '0)
    else $error("nonzero value outside window");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    ctl_in.valid && width == 32'd0 |-> !ctl_in.inw)
    else $error("zero width taken as inside window");
`endif

endmodule

// ===== hw/rtl/kbw_div.sv =====
`timescale 1ns / 1ps
module kbw_div
  import kbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       width,
  input  kbw_ctl_t          ctl_in,
  input  logic [31:0]       num_in,
  output kbw_ctl_t          ctl_out,
  output logic [FRAC-1:0]   quo_out
);

  // one quotient bit per stage: r = floor(num * 2^60 / W)
  kbw_ctl_t          ctl [DIV_STEPS+1];
  logic [31:0]       rem [DIV_STEPS+1];
  logic [FRAC-1:0]   quo [DIV_STEPS+1];

  assign ctl[0] = ctl_in;
  assign rem[0] = num_in;
  assign quo[0] = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    assign rem_sh  = {rem[g], 1'b0};
    assign ge      = rem_sh >= {1'b0, width};
    assign rem_sub = rem_sh - {1'b0, width};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[g+1].valid <= 1'b0;
      end else begin
        ctl[g+1].valid <= ctl[g].valid;
      end
      ctl[g+1].inw <= ctl[g].inw;
      rem[g+1] <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo[g+1] <= {quo[g][FRAC-2:0], ge};
    end
  end

  assign ctl_out = ctl[DIV_STEPS];
  assign quo_out = quo[DIV_STEPS];

endmodule

// ===== hw/rtl/kbw_mac.sv =====
`timescale 1ns / 1ps
module kbw_mac
  import kbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  kbw_ctl_t    ctl_in,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  input  logic [63:0] aux_in,
  output kbw_ctl_t    ctl_out,
  output logic [63:0] result,
  output logic [63:0] aux_out
);

  // floor(a*b / 2^60) + c, three stages: partials, sum, add
  kbw_ctl_t     ctl_a, ctl_b;
  logic [63:0]  aux_a, aux_b;
  logic [63:0]  c_a, c_b;
  logic [63:0]  ll, lh, hl, hh;
  logic [127:0] prod;
  logic [127:0] prod_sum;

  assign prod_sum = {64'd0, ll} + ({64'd0, lh} << 32) + ({64'd0, hl} << 32) + {hh, 64'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid   <= 1'b0;
      ctl_b.valid   <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_a.valid   <= ctl_in.valid;
      ctl_b.valid   <= ctl_a.valid;
      ctl_out.valid <= ctl_b.valid;
    end
    ctl_a.inw   <= ctl_in.inw;
    ctl_b.inw   <= ctl_a.inw;
    ctl_out.inw <= ctl_b.inw;
    aux_a   <= aux_in;
    aux_b   <= aux_a;
    aux_out <= aux_b;
    c_a <= c;
    c_b <= c_a;
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    hh <= a[63:32] * b[63:32];
    prod <= prod_sum;
    result <= prod[FRAC+63:FRAC] + c_b;
  end

endmodule
